/* src/llj_pkg.sv */
// Shared types and constants for the logical line joiner.
`default_nettype none
package llj_pkg;

	localparam int LINE_COUNT_BITS_DEF = 16;
	localparam int LINE_NUM_BITS = 16;
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_CNT_BITS = $clog2(OUTQ_DEPTH + 1);

	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;

	typedef enum logic [1:0] {
		PH_WANT = 2'd0,
		PH_COMMENT = 2'd1,
		PH_TEXT = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic end_of_input;
	} req_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic has_byte;
		logic line_end;
		logic input_end;
		logic [LINE_NUM_BITS-1:0] line_number;
	} rsp_word_t;

	typedef struct packed {
		phase_t phase;
		logic nonempty;
		logic first_hash;
		logic pending;
	} line_state_t;

	localparam line_state_t LINE_CLEAR = '{phase: PH_WANT, nonempty: 1'b0,
		first_hash: 1'b0, pending: 1'b0};

endpackage
`default_nettype wire

/* src/llj_step.sv */
// Per-byte line state update and result formation.
`default_nettype none
module llj_step #(
	parameter int LINE_COUNT_BITS = llj_pkg::LINE_COUNT_BITS_DEF
) (
	input  llj_pkg::req_word_t             word,
	input  logic                           strip,
	input  llj_pkg::line_state_t           state,
	input  logic [LINE_COUNT_BITS-1:0]     count,
	output llj_pkg::line_state_t           next_state,
	output logic [LINE_COUNT_BITS-1:0]     next_count,
	output logic [1:0]                     res_n,
	output llj_pkg::rsp_word_t             res0,
	output llj_pkg::rsp_word_t             res1
);
	import llj_pkg::*;

	logic [LINE_NUM_BITS-1:0] shown_old;
	logic [LINE_NUM_BITS-1:0] shown_new;
	logic [7:0] c;
	logic blank;
	logic count_inc;

	assign c = word.byte_value;
	assign blank = (c == CH_SPACE) || (c == CH_TAB);
	assign count_inc = !word.end_of_input && (c == CH_NL);
	assign next_count = (count_inc && (count != '1)) ? count + 1'b1 : count;

	generate
		if (LINE_COUNT_BITS > LINE_NUM_BITS) begin : g_sat
			assign shown_old = (|count[LINE_COUNT_BITS-1:LINE_NUM_BITS]) ?
				'1 : count[LINE_NUM_BITS-1:0];
			assign shown_new = (|next_count[LINE_COUNT_BITS-1:LINE_NUM_BITS]) ?
				'1 : next_count[LINE_NUM_BITS-1:0];
		end else begin : g_ext
			assign shown_old = LINE_NUM_BITS'(count);
			assign shown_new = LINE_NUM_BITS'(next_count);
		end
	endgenerate

	always_comb begin
		line_state_t st;
		logic a_v;
		logic b_v;
		logic done;
		rsp_word_t a;
		rsp_word_t b;
		st = state;
		a_v = 1'b0;
		b_v = 1'b0;
		done = 1'b0;
		a = '{out_byte: 8'd0, has_byte: 1'b0, line_end: 1'b1, input_end: 1'b0,
			line_number: shown_old};
		b = '{out_byte: 8'd0, has_byte: 1'b0, line_end: 1'b0, input_end: 1'b0,
			line_number: shown_new};
		if (word.end_of_input) begin
			a_v = state.pending || state.nonempty;
			st = LINE_CLEAR;
			b_v = 1'b1;
			b.input_end = 1'b1;
		end else begin
			if (state.pending) begin
				st.pending = 1'b0;
				if (blank) begin
					if (!st.nonempty)
						st.first_hash = (c == CH_HASH);
					st.nonempty = 1'b1;
					b_v = 1'b1;
					b.has_byte = 1'b1;
					b.out_byte = c;
					done = 1'b1;
				end else begin
					a_v = 1'b1;
					st = LINE_CLEAR;
				end
			end
			if (!done) begin
				if (!st.nonempty && blank) begin
					b_v = 1'b0;
				end else if (c == CH_NL) begin
					st.phase = PH_WANT;
					if (strip) begin
						st.pending = st.nonempty;
					end else if (!st.nonempty || st.first_hash) begin
						b_v = 1'b1;
						b.has_byte = 1'b1;
						b.line_end = 1'b1;
						b.out_byte = c;
						st = LINE_CLEAR;
					end else begin
						b_v = 1'b1;
						b.has_byte = 1'b1;
						b.out_byte = c;
						st.pending = 1'b1;
					end
				end else begin
					if (st.phase == PH_WANT) begin
						if (c == CH_HASH)
							st.phase = PH_COMMENT;
						else if (!blank)
							st.phase = PH_TEXT;
					end
					if (!(strip && st.phase == PH_COMMENT)) begin
						if (!st.nonempty)
							st.first_hash = (c == CH_HASH);
						st.nonempty = 1'b1;
						b_v = 1'b1;
						b.has_byte = 1'b1;
						b.out_byte = c;
					end
				end
			end
		end
		next_state = st;
		res_n = {1'b0, a_v} + {1'b0, b_v};
		res0 = a_v ? a : b;
		res1 = b;
	end

endmodule
`default_nettype wire

/* src/llj_outq.sv */
// Small shifting result queue, up to two words pushed per cycle.
`default_nettype none
module llj_outq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [1:0]                          push_n,
	input  llj_pkg::rsp_word_t                  push0,
	input  llj_pkg::rsp_word_t                  push1,
	output logic                                room,
	output llj_pkg::rsp_word_t                  rsp_word,
	output logic                                rsp_valid,
	input  logic                                rsp_ready
);
	import llj_pkg::*;

	rsp_word_t ent_q [OUTQ_DEPTH];
	logic [OUTQ_CNT_BITS-1:0] cnt_q;
	logic pop;
	logic [OUTQ_CNT_BITS-1:0] base;

	assign rsp_valid = (cnt_q != '0);
	assign rsp_word = ent_q[0];
	assign pop = rsp_valid && rsp_ready;
	assign room = (cnt_q <= OUTQ_CNT_BITS'(OUTQ_DEPTH - 2));
	assign base = cnt_q - OUTQ_CNT_BITS'(pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= base + OUTQ_CNT_BITS'(push_n);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < OUTQ_DEPTH; i++) begin
			if (push_n != 2'd0 && OUTQ_CNT_BITS'(i) == base)
				ent_q[i] <= push0;
			else if (push_n == 2'd2 && OUTQ_CNT_BITS'(i) == base + 1'b1)
				ent_q[i] <= push1;
			else if (pop && i + 1 < OUTQ_DEPTH)
				ent_q[i] <= ent_q[(i + 1) % OUTQ_DEPTH];
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= OUTQ_CNT_BITS'(OUTQ_DEPTH))
		else $error("result queue overfilled");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> room)
		else $error("push without room");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_word)))
		else $error("result word changed while waiting");

endmodule
`default_nettype wire

/* src/logical_line_joiner_unit.sv */
// Top level of the logical line joiner.
// Each accepted word is registered, run through the line-state logic and
// turned into zero, one or two result words in a four-word output queue.
// One word is accepted per cycle while the queue has room for two results;
// a word that closes a pending line and opens a new one yields two results,
// so the sustained rate is one word per cycle for input that gives at most
// one result per word, set by the single result port. Results pass from the
// input register through the queue register. The line counter saturates at
// its maximum value; line_number shows it capped at 65535.
`default_nettype none
module logical_line_joiner_unit #(
	parameter int LINE_COUNT_BITS = llj_pkg::LINE_COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  llj_pkg::req_word_t  req_word,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output llj_pkg::rsp_word_t  rsp_word,
	input  logic                cfg_we,
	input  logic                cfg_wdata
);
	import llj_pkg::*;

	logic valid_s1;
	req_word_t word_s1;
	logic strip_q;
	line_state_t state_q;
	logic [LINE_COUNT_BITS-1:0] count_q;
	line_state_t next_state;
	logic [LINE_COUNT_BITS-1:0] next_count;
	logic [1:0] res_n;
	rsp_word_t res0;
	rsp_word_t res1;
	logic room;
	logic advance;

	assign advance = valid_s1 && room;
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			strip_q <= 1'b1;
			state_q <= LINE_CLEAR;
			count_q <= '0;
		end else begin
			if (cfg_we)
				strip_q <= cfg_wdata;
			if (req_ready)
				valid_s1 <= req_valid;
			if (advance) begin
				state_q <= next_state;
				count_q <= next_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready)
			word_s1 <= req_word;
	end

	llj_step #(
		.LINE_COUNT_BITS(LINE_COUNT_BITS)
	) u_step (
		.word(word_s1),
		.strip(strip_q),
		.state(state_q),
		.count(count_q),
		.next_state(next_state),
		.next_count(next_count),
		.res_n(res_n),
		.res0(res0),
		.res1(res1)
	);

	llj_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push_n(advance ? res_n : 2'd0),
		.push0(res0),
		.push1(res1),
		.room(room),
		.rsp_word(rsp_word),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready)
	);

	a_pending_open: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pending |-> state_q.nonempty)
		else $error("pending newline on empty line");
	a_eoi_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && word_s1.end_of_input) |=>
		(!state_q.pending && !state_q.nonempty && state_q.phase == PH_WANT))
		else $error("line state not cleared at end of input");
	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q >= $past(count_q)))
		else $error("line count went down");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the logical line joiner: queued stimulus, clocked driver/monitor.
module tb_top;
	import llj_pkg::*;

	localparam int CNT_BITS = 8;
	localparam int SETTLE_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_word_t req_word = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_word_t rsp_word;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	req_word_t outgoing_text[$];
	rsp_word_t joined_words[$];
	int mismatch_count = 0;
	bit calm = 1'b0;
	int send_gap = 0;
	int recv_stall = 0;

	bit strip_mode = 1'b1;
	phase_t line_phase = PH_WANT;
	bit line_open = 1'b0;
	bit opened_by_hash = 1'b0;
	bit nl_held = 1'b0;
	logic [CNT_BITS-1:0] nl_total = '0;

	logical_line_joiner_unit #(.LINE_COUNT_BITS(CNT_BITS)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_word(req_word),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_word(rsp_word),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB;
	endfunction

	function automatic void emit_word(logic [7:0] b, bit hb, bit le, bit ie);
		rsp_word_t r;
		r.out_byte = hb ? b : 8'h00;
		r.has_byte = hb;
		r.line_end = le;
		r.input_end = ie;
		r.line_number = (nl_total > 16'hFFFF) ? 16'hFFFF : 16'(nl_total);
		joined_words.push_back(r);
	endfunction

	function automatic void clear_line();
		line_phase = PH_WANT;
		line_open = 1'b0;
		opened_by_hash = 1'b0;
		nl_held = 1'b0;
	endfunction

	function automatic void append_byte(logic [7:0] c);
		if (!line_open) begin
			opened_by_hash = (c == CH_HASH);
		end
		line_open = 1'b1;
		emit_word(c, 1'b1, 1'b0, 1'b0);
	endfunction

	function automatic void join_byte(req_word_t w);
		logic [7:0] c;
		c = w.byte_value;
		if (w.end_of_input) begin
			if (nl_held || line_open) begin
				emit_word(8'h00, 1'b0, 1'b1, 1'b0);
			end
			clear_line();
			emit_word(8'h00, 1'b0, 1'b0, 1'b1);
			return;
		end
		if (nl_held) begin
			nl_held = 1'b0;
			if (is_blank(c)) begin
				append_byte(c);
				return;
			end
			emit_word(8'h00, 1'b0, 1'b1, 1'b0);
			clear_line();
		end
		if (!line_open && is_blank(c)) begin
			return;
		end
		if (c == CH_NL) begin
			if (nl_total != '1) begin
				nl_total++;
			end
			line_phase = PH_WANT;
			if (strip_mode) begin
				if (line_open) begin
					nl_held = 1'b1;
				end
				return;
			end
			if (!line_open || opened_by_hash) begin
				emit_word(c, 1'b1, 1'b1, 1'b0);
				clear_line();
				return;
			end
			append_byte(c);
			nl_held = 1'b1;
			return;
		end
		if (line_phase == PH_WANT) begin
			if (c == CH_HASH) begin
				line_phase = PH_COMMENT;
			end else if (!is_blank(c)) begin
				line_phase = PH_TEXT;
			end
		end
		if (strip_mode && line_phase == PH_COMMENT) begin
			return;
		end
		append_byte(c);
	endfunction

	// driver: hold the word until accepted, predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_word <= '0;
			send_gap = 0;
			strip_mode = 1'b1;
			nl_total = '0;
			clear_line();
		end else begin
			if (cfg_we) begin
				strip_mode = cfg_wdata;
			end
			if (req_valid && req_ready) begin
				join_byte(req_word);
			end
			if (!req_valid || req_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (outgoing_text.size() > 0) begin
					req_valid <= 1'b1;
					req_word <= outgoing_text.pop_front();
					if (!calm && $urandom_range(0, 7) == 0) begin
						send_gap = $urandom_range(1, 8);
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	task automatic flag_error(string what, rsp_word_t e, rsp_word_t a);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%s: expected byte=%h has=%b end=%b eoi=%b num=%0d, got byte=%h has=%b end=%b eoi=%b num=%0d",
				what, e.out_byte, e.has_byte, e.line_end, e.input_end, e.line_number,
				a.out_byte, a.has_byte, a.line_end, a.input_end, a.line_number);
		end
	endtask

	// monitor: compare each result word with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		rsp_word_t e;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (joined_words.size() == 0) begin
					flag_error("unexpected word", '0, rsp_word);
				end else begin
					e = joined_words.pop_front();
					if (rsp_word.out_byte !== e.out_byte || rsp_word.has_byte !== e.has_byte ||
						rsp_word.line_end !== e.line_end ||
						rsp_word.input_end !== e.input_end ||
						rsp_word.line_number !== e.line_number) begin
						flag_error("mismatch", e, rsp_word);
					end
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				rsp_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				recv_stall = $urandom_range(0, 7);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	function automatic void push_byte(logic [7:0] b);
		outgoing_text.push_back('{byte_value: b, end_of_input: 1'b0});
	endfunction

	function automatic void push_eoi(logic [7:0] b);
		outgoing_text.push_back('{byte_value: b, end_of_input: 1'b1});
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			push_byte(s[i]);
		end
	endfunction

	function automatic logic [7:0] text_char();
		case ($urandom_range(0, 9))
			0: return CH_HASH;
			1: return CH_SPACE;
			2: return CH_TAB;
			3: return 8'($urandom_range(0, 255));
			default: return 8'("a" + $urandom_range(0, 25));
		endcase
	endfunction

	function automatic void push_chars(int n);
		for (int i = 0; i < n; i++) begin
			push_byte(text_char());
		end
	endfunction

	function automatic void push_blanks(int n);
		for (int i = 0; i < n; i++) begin
			push_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
		end
	endfunction

	function automatic void make_lines(int n);
		int target;
		int kind;
		target = outgoing_text.size() + n;
		while (outgoing_text.size() < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 12) begin
				repeat ($urandom_range(1, 10)) push_byte(CH_NL);
			end else if (kind < 24) begin
				push_blanks($urandom_range(0, 2));
				push_byte(CH_HASH);
				push_chars($urandom_range(0, 4));
				push_byte(CH_NL);
			end else if (kind < 44) begin
				push_blanks($urandom_range(1, 2));
				push_chars($urandom_range(0, 4));
				push_byte(CH_NL);
			end else if (kind < 80) begin
				push_blanks($urandom_range(0, 2));
				push_chars($urandom_range(1, 6));
				if ($urandom_range(0, 9) != 0) begin
					push_byte(CH_NL);
				end
			end else if (kind < 92) begin
				repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
			end else begin
				push_eoi(8'($urandom_range(0, 255)));
			end
		end
	endfunction

	task automatic write_strip(bit v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		do @(negedge clk);
		while (outgoing_text.size() != 0 || req_valid || joined_words.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		push_text(" a\n\tb\n#c\n\nd");
		push_byte(8'hFF);
		push_byte(8'h00);
		push_eoi(8'hFF);
		drain();

		write_strip(1'b0);
		@(negedge clk);
		push_text("\n#q\nx\n y\n");
		push_eoi(8'h00);
		push_eoi(8'h5A);
		drain();

		for (int p = 0; p < 6; p++) begin
			write_strip(p % 2 == 0);
			if (p == 5) begin
				calm = 1'b1;
			end
			@(negedge clk);
			make_lines(100);
			drain();
		end

		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
